// ===== sv/gmdff_pkg.sv =====
package gmdff_pkg;

	localparam int GRID_W = 128;
	localparam int GRID_H = 128;
	localparam int CXW = $clog2(GRID_W);
	localparam int CYW = $clog2(GRID_H);

	localparam int COORD_W = 12;
	localparam int DIV_W = 7;
	localparam int DIV_LANES = 4;
	localparam int STEP_W = $clog2(COORD_W);

	localparam int LN_X = 0;
	localparam int LN_Y = 1;
	localparam int LN_W = 2;
	localparam int LN_H = 3;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W = 16;
	localparam int ID_W = 32;

	typedef enum logic [1:0] {
		ST_ACCEPT   = 2'd0,
		ST_BORDER   = 2'd1,
		ST_OCCUPIED = 2'd2,
		ST_LIMIT    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_DIST  = 3'd0,
		CFG_PATCH     = 3'd1,
		CFG_IMG_W     = 3'd2,
		CFG_IMG_H     = 3'd3,
		CFG_MAX_FEAT  = 3'd4,
		CFG_FIRST_ID  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROW_C,
		ROW_U,
		ROW_D
	} row_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_CLAMP,
		S_RD_C,
		S_WR_C,
		S_RD_U,
		S_WR_U,
		S_RD_D,
		S_WR_D,
		S_ACCEPT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     div_start;
		logic     clamp;
		logic     mem_rd;
		logic     mem_wr;
		row_sel_t row_sel;
		logic     set_status;
		status_t  status_val;
		logic     accept;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic limit_hit;
		logic border_fail;
		logic grid_on;
		logic div_done;
		logic occupied;
		logic has_up;
		logic has_down;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/gmdff_div.sv =====
module gmdff_div (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     start,
	input  logic [gmdff_pkg::DIV_W-1:0]                              divisor,
	input  logic [gmdff_pkg::DIV_LANES-1:0][gmdff_pkg::COORD_W-1:0]  dividend,
	output logic [gmdff_pkg::DIV_LANES-1:0][gmdff_pkg::COORD_W-1:0]  quotient,
	output logic                                                     done
);
	import gmdff_pkg::*;

	logic [DIV_LANES-1:0][DIV_W-1:0]   rem_q;
	logic [DIV_LANES-1:0][COORD_W-1:0] quo_q;
	logic [DIV_W-1:0]                  dvs_q;
	logic                              busy_q;
	logic [STEP_W-1:0]                 step_q;

	logic [DIV_LANES-1:0][DIV_W-1:0]   rem_n;
	logic [DIV_LANES-1:0][COORD_W-1:0] quo_n;
	logic [DIV_LANES-1:0][DIV_W:0]     trial;

	// one restoring step per cycle, all lanes share the divisor
	always_comb begin
		for (int i = 0; i < DIV_LANES; i++) begin
			trial[i] = {rem_q[i], quo_q[i][COORD_W-1]};
			if (trial[i] >= {1'b0, dvs_q}) begin
				rem_n[i] = DIV_W'(trial[i] - {1'b0, dvs_q});
				quo_n[i] = {quo_q[i][COORD_W-2:0], 1'b1};
			end else begin
				rem_n[i] = trial[i][DIV_W-1:0];
				quo_n[i] = {quo_q[i][COORD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= STEP_W'(step_q + 1'b1);
			if (step_q == STEP_W'(COORD_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done = busy_q && (step_q == STEP_W'(COORD_W - 1));

endmodule

// ===== sv/gmdff_dp.sv =====
module gmdff_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gmdff_pkg::cmd_t                      cmd,
	output gmdff_pkg::stat_t                     stat,
	input  logic                                 cfg_wr_en,
	input  logic [gmdff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmdff_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 start_frame,
	input  logic [gmdff_pkg::COORD_W-1:0]        pos_x,
	input  logic [gmdff_pkg::COORD_W-1:0]        pos_y,
	input  logic signed [31:0]                   score,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [gmdff_pkg::ID_W-1:0]           feature_id,
	output logic [gmdff_pkg::COORD_W-1:0]        out_x,
	output logic [gmdff_pkg::COORD_W-1:0]        out_y,
	output logic signed [31:0]                   out_score
);
	import gmdff_pkg::*;

	// configuration
	logic [7:0]         min_dist_q;
	logic [7:0]         patch_q;
	logic [COORD_W-1:0] img_w_q;
	logic [COORD_W-1:0] img_h_q;
	logic [CNT_W-1:0]   max_feat_q;
	logic [ID_W-1:0]    first_id_q;

	// frame state
	logic [CNT_W-1:0]   count_q;
	logic [ID_W-1:0]    next_id_q;
	logic [GRID_H-1:0]  row_vld_q;

	// item being judged
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic signed [31:0] score_q;
	status_t            status_q;
	logic [ID_W-1:0]    id_q;

	logic [CXW-1:0]     cx_q;
	logic [CYW-1:0]     cy_q;
	logic [CXW-1:0]     limx_q;
	logic [CYW-1:0]     limy_q;

	// grid rows
	logic [GRID_W-1:0]  grid_mem [GRID_H];
	logic [GRID_W-1:0]  rd_row_q;
	logic               rd_vld_q;

	logic               out_vld_q;
	status_t            out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic signed [31:0] out_score_q;

	logic [DIV_LANES-1:0][COORD_W-1:0] dvd;
	logic [DIV_LANES-1:0][COORD_W-1:0] quo;
	logic               div_done;

	logic [DIV_W-1:0]   margin;
	logic [COORD_W:0]   x_far;
	logic [COORD_W:0]   y_far;
	logic [CXW-1:0]     limx;
	logic [CYW-1:0]     limy;
	logic [CYW-1:0]     row_addr;
	logic [GRID_W-1:0]  row_cur;
	logic [GRID_W-1:0]  wr_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= '0;
			patch_q    <= '0;
			img_w_q    <= COORD_W'(640);
			img_h_q    <= COORD_W'(480);
			max_feat_q <= '0;
			first_id_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_DIST: min_dist_q <= cfg_data[7:0];
				CFG_PATCH:    patch_q    <= cfg_data[7:0];
				CFG_IMG_W:    img_w_q    <= cfg_data[COORD_W-1:0];
				CFG_IMG_H:    img_h_q    <= cfg_data[COORD_W-1:0];
				CFG_MAX_FEAT: max_feat_q <= cfg_data[CNT_W-1:0];
				CFG_FIRST_ID: first_id_q <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// a cleared row reads as empty until it is written again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= '0;
			row_vld_q <= '0;
		end else if (cmd.capture && start_frame) begin
			count_q   <= '0;
			next_id_q <= first_id_q;
			row_vld_q <= '0;
		end else begin
			if (cmd.accept) begin
				next_id_q <= next_id_q + 1'b1;
				if (count_q != {CNT_W{1'b1}})
					count_q <= CNT_W'(count_q + 1'b1);
			end
			if (cmd.mem_wr)
				row_vld_q[row_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q      <= pos_x;
			y_q      <= pos_y;
			score_q  <= score;
			status_q <= ST_ACCEPT;
			id_q     <= '0;
		end else begin
			if (cmd.set_status)
				status_q <= cmd.status_val;
			if (cmd.accept)
				id_q <= next_id_q;
		end
	end

	assign margin = patch_q[7:1];
	assign x_far = {1'b0, x_q} + (COORD_W+1)'(margin);
	assign y_far = {1'b0, y_q} + (COORD_W+1)'(margin);

	assign dvd[LN_X] = x_q;
	assign dvd[LN_Y] = y_q;
	assign dvd[LN_W] = img_w_q;
	assign dvd[LN_H] = img_h_q;

	gmdff_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (min_dist_q[7:1]),
		.dividend (dvd),
		.quotient (quo),
		.done     (div_done)
	);

	// last usable cell index: min(extent/cell, grid size - 1)
	assign limx = (quo[LN_W] > COORD_W'(GRID_W - 1)) ? CXW'(GRID_W - 1) : quo[LN_W][CXW-1:0];
	assign limy = (quo[LN_H] > COORD_W'(GRID_H - 1)) ? CYW'(GRID_H - 1) : quo[LN_H][CYW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			limx_q <= limx;
			limy_q <= limy;
			cx_q   <= (quo[LN_X] > COORD_W'(limx)) ? limx : quo[LN_X][CXW-1:0];
			cy_q   <= (quo[LN_Y] > COORD_W'(limy)) ? limy : quo[LN_Y][CYW-1:0];
		end
	end

	always_comb begin
		case (cmd.row_sel)
			ROW_U:   row_addr = CYW'(cy_q - 1'b1);
			ROW_D:   row_addr = CYW'(cy_q + 1'b1);
			default: row_addr = cy_q;
		endcase
	end

	assign row_cur = rd_vld_q ? rd_row_q : '0;

	always_comb begin
		wr_mask = '0;
		wr_mask[cx_q] = 1'b1;
		if (cmd.row_sel == ROW_C) begin
			if (cx_q != '0)
				wr_mask[CXW'(cx_q - 1'b1)] = 1'b1;
			if (cx_q != limx_q)
				wr_mask[CXW'(cx_q + 1'b1)] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_row_q <= grid_mem[row_addr];
			rd_vld_q <= row_vld_q[row_addr];
		end
		if (cmd.mem_wr)
			grid_mem[row_addr] <= row_cur | wr_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.load_out)
			out_vld_q <= 1'b1;
		else if (!out_stall)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_id_q     <= id_q;
			out_x_q      <= x_q;
			out_y_q      <= y_q;
			out_score_q  <= score_q;
		end
	end

	assign stat.limit_hit   = (max_feat_q != '0) && (count_q >= max_feat_q);
	assign stat.border_fail = !((x_q > COORD_W'(margin)) && (x_far < {1'b0, img_w_q}) &&
	                            (y_q > COORD_W'(margin)) && (y_far < {1'b0, img_h_q}));
	assign stat.grid_on     = min_dist_q > 8'd1;
	assign stat.div_done    = div_done;
	assign stat.occupied    = row_cur[cx_q];
	assign stat.has_up      = cy_q != '0;
	assign stat.has_down    = cy_q != limy_q;
	assign stat.out_free    = !out_vld_q || !out_stall;

	assign out_valid  = out_vld_q;
	assign status     = out_status_q;
	assign feature_id = out_id_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_score  = out_score_q;

endmodule

// ===== sv/gmdff_ctrl.sv =====
module gmdff_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gmdff_pkg::stat_t  stat,
	output gmdff_pkg::cmd_t   cmd
);
	import gmdff_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		cmd.row_sel = ROW_C;
		cmd.status_val = ST_ACCEPT;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.limit_hit) begin
					cmd.set_status = 1'b1;
					cmd.status_val = ST_LIMIT;
					state_n = S_DONE;
				end else if (stat.border_fail) begin
					cmd.set_status = 1'b1;
					cmd.status_val = ST_BORDER;
					state_n = S_DONE;
				end else if (stat.grid_on) begin
					cmd.div_start = 1'b1;
					state_n = S_DIV;
				end else begin
					state_n = S_ACCEPT;
				end
			end
			S_DIV: begin
				if (stat.div_done)
					state_n = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_n = S_RD_C;
			end
			S_RD_C: begin
				cmd.mem_rd = 1'b1;
				state_n = S_WR_C;
			end
			S_WR_C: begin
				// drop the point if its cell is taken, else claim it
				if (stat.occupied) begin
					cmd.set_status = 1'b1;
					cmd.status_val = ST_OCCUPIED;
					state_n = S_DONE;
				end else begin
					cmd.mem_wr = 1'b1;
					if (stat.has_up)
						state_n = S_RD_U;
					else if (stat.has_down)
						state_n = S_RD_D;
					else
						state_n = S_ACCEPT;
				end
			end
			S_RD_U: begin
				cmd.mem_rd = 1'b1;
				cmd.row_sel = ROW_U;
				state_n = S_WR_U;
			end
			S_WR_U: begin
				cmd.mem_wr = 1'b1;
				cmd.row_sel = ROW_U;
				state_n = stat.has_down ? S_RD_D : S_ACCEPT;
			end
			S_RD_D: begin
				cmd.mem_rd = 1'b1;
				cmd.row_sel = ROW_D;
				state_n = S_WR_D;
			end
			S_WR_D: begin
				cmd.mem_wr = 1'b1;
				cmd.row_sel = ROW_D;
				state_n = S_ACCEPT;
			end
			S_ACCEPT: begin
				cmd.accept = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// ===== sv/grid_min_distance_feature_filter.sv =====
// channel | direction | handshake             | beat
// in      | input     | in_valid / in_stall   | start_frame, pos_x, pos_y, score
// out     | output    | out_valid / out_stall | status, feature_id, out_x, out_y, out_score
// cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One point at a time. A point stopped by the limit or the border check goes from the
// check state to the done state; one passed without the grid goes through the accept
// state first; with the grid it first runs the shared 4-lane restoring divider, then
// read-modify-writes of up to three grid rows through the single-port row memory.
// Reset at once clears the grid (per-row valid flops) and counters, resets the config.
// A new point is taken while the previous result still waits in the output register.
module grid_min_distance_feature_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [gmdff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmdff_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 start_frame,
	input  logic [gmdff_pkg::COORD_W-1:0]        pos_x,
	input  logic [gmdff_pkg::COORD_W-1:0]        pos_y,
	input  logic signed [31:0]                   score,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [gmdff_pkg::ID_W-1:0]           feature_id,
	output logic [gmdff_pkg::COORD_W-1:0]        out_x,
	output logic [gmdff_pkg::COORD_W-1:0]        out_y,
	output logic signed [31:0]                   out_score
);
	import gmdff_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	gmdff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	gmdff_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start_frame (start_frame),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.score       (score),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.feature_id  (feature_id),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_score   (out_score)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mem_wr && cmd.row_sel == ROW_C) |-> !stat.occupied)
		else $error("claimed a grid cell that was already occupied");

	a_accept_under_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !stat.limit_hit)
		else $error("point accepted past the frame limit");

	a_reject_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_ACCEPT) |-> (feature_id == '0))
		else $error("rejected point carries an id");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.div_start, cmd.clamp, cmd.mem_rd, cmd.mem_wr,
		          cmd.accept, cmd.load_out}))
		else $error("controller issued overlapping commands");
`endif

endmodule
